/* rtl/core/akrt_pkg.sv */
// ----------------------------------------------------------------------------
// akrt_pkg
// Types, codes and constants shared by the analog-key rapid-trigger block.
// ----------------------------------------------------------------------------
package akrt_pkg;

  localparam int NUM_KEYS         = 64;
  localparam int KEY_W            = 6;
  localparam int CAL_SAMPLES      = 16;
  localparam int IDLE_START       = 2048;
  localparam int MAX_TRAVEL_START = 1000;
  localparam int SAMPLE_BITS      = 12;
  localparam int ADDR_W           = 6;
  localparam int DATA_W           = 64;

  localparam logic [1:0] REQ_SCAN   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_TAP    = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  localparam logic [2:0] REG_TRIGGER_LEVEL = 3'd0;
  localparam logic [2:0] REG_RESET_GAP     = 3'd1;
  localparam logic [2:0] REG_RAPID_GAP     = 3'd2;
  localparam logic [2:0] REG_TAP_WINDOW    = 3'd3;
  localparam logic [2:0] REG_TAP_MASK      = 3'd4;
  localparam logic [2:0] REG_IDLE_MARGIN   = 3'd5;
  localparam logic [2:0] REG_BOTTOM_MARGIN = 3'd6;
  localparam logic [2:0] REG_SLEEP_COUNT   = 3'd7;

  typedef enum logic [2:0] {
    PH_RESET     = 3'd0,
    PH_RAPID     = 3'd1,
    PH_MAYBE_TAP = 3'd2,
    PH_TAP       = 3'd3,
    PH_TRIG      = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    OP_SCAN,
    OP_SAMPLE,
    OP_TAP,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CAL,
    ST_DIST,
    ST_CLAMP,
    ST_DIV,
    ST_FILT,
    ST_ACT,
    ST_WB,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [KEY_W-1:0]       key_index;
    logic [SAMPLE_BITS-1:0] sample;
    logic [31:0]            now_ms;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic [1:0]       event_res;
    logic             layer;
    logic [7:0]       travel_level;
    logic             sleeping;
  } out_item_t;

  typedef struct packed {
    op_t                    op;
    logic [KEY_W-1:0]       key;
    logic [SAMPLE_BITS-1:0] sample;
    logic [31:0]            now_ms;
  } work_t;

  typedef struct packed {
    logic [7:0]  trigger_level;
    logic [7:0]  reset_gap;
    logic [7:0]  rapid_gap;
    logic [15:0] tap_window_ms;
    logic [63:0] tap_key_mask;
    logic [11:0] idle_margin;
    logic [11:0] bottom_margin;
    logic [15:0] sleep_count;
  } cfg_t;

  typedef struct packed {
    logic [4:0]        cal_count;
    logic [15:0]       idle_level;
    logic [11:0]       max_travel;
    logic [11:0]       prev_travel;
    logic [7:0]        travel_scaled;
    logic [15:0]       filtered_travel;
    logic signed [8:0] speed;
    dir_t              heading;
    logic [7:0]        turn_point;
    phase_t            phase;
    logic [31:0]       trigger_time;
    logic [15:0]       quiet_count;
    logic              asleep;
  } key_rec_t;

  localparam key_rec_t REC_RESET = '{
    cal_count:       5'd0,
    idle_level:      16'(IDLE_START * 16),
    max_travel:      12'(MAX_TRAVEL_START),
    prev_travel:     12'd0,
    travel_scaled:   8'd0,
    filtered_travel: 16'd0,
    speed:           9'sd0,
    heading:         DIR_NONE,
    turn_point:      8'd0,
    phase:           PH_RESET,
    trigger_time:    32'd0,
    quiet_count:     16'd0,
    asleep:          1'b0
  };

endpackage

/* rtl/core/akrt_front.sv */
// ----------------------------------------------------------------------------
// akrt_front
// Input queue: accepts items, decodes the request type and holds them for
// the sequencer.
// ----------------------------------------------------------------------------
module akrt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  akrt_pkg::in_item_t in_item,
  output logic               fr_valid,
  input  logic               fr_pop,
  output akrt_pkg::work_t    fr_work
);

  akrt_pkg::work_t q_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  akrt_pkg::work_t dec;
  logic            do_push;
  logic            do_pop;

  // classify the request
  always_comb begin
    dec.key    = in_item.key_index;
    dec.sample = in_item.sample;
    dec.now_ms = in_item.now_ms;
    unique case (in_item.req_type)
      akrt_pkg::REQ_SCAN:   dec.op = akrt_pkg::OP_SCAN;
      akrt_pkg::REQ_SAMPLE: dec.op = akrt_pkg::OP_SAMPLE;
      akrt_pkg::REQ_TAP:    dec.op = akrt_pkg::OP_TAP;
      default:              dec.op = akrt_pkg::OP_NOP;
    endcase
  end

  assign full     = (cnt_r == 2'd2);
  assign fr_valid = (cnt_r != 2'd0);
  assign fr_work  = q_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = fr_pop && fr_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* rtl/core/akrt_div.sv */
// ----------------------------------------------------------------------------
// akrt_div
// Restoring divider, one quotient bit per cycle; quotient is known to fit
// in eight bits because the numerator is below 256 times the divisor.
// ----------------------------------------------------------------------------
module akrt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [19:0] num,
  input  logic [11:0] den,
  output logic        done,
  output logic [7:0]  quot
);

  logic        busy_r;
  logic        done_r;
  logic [2:0]  step_r;
  logic [19:0] rem_r;
  logic [11:0] den_r;
  logic [7:0]  quot_r;
  logic [19:0] shifted;
  logic        fits;

  assign shifted = {8'd0, den_r} << step_r;
  assign fits    = (rem_r >= shifted);
  assign done    = done_r;
  assign quot    = quot_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= 8'd0;
    end else if (busy_r && fits) begin
      rem_r          <= rem_r - shifted;
      quot_r[step_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd7;
      end else if (busy_r) begin
        step_r <= step_r - 3'd1;
        if (step_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/akrt_back.sv */
// ----------------------------------------------------------------------------
// akrt_back
// Per-key sequencer: reads the key record, runs calibration, travel, scaling,
// filtering and the actuation machine, writes the record back, emits a result.
// ----------------------------------------------------------------------------
module akrt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  akrt_pkg::cfg_t      cfg,
  input  logic                fr_valid,
  output logic                fr_pop,
  input  akrt_pkg::work_t     fr_work,
  output logic                res_valid,
  input  logic                res_ready,
  output akrt_pkg::out_item_t res_item
);

  akrt_pkg::seq_state_t state_r, state_nxt;

  akrt_pkg::key_rec_t  mem [akrt_pkg::NUM_KEYS];
  akrt_pkg::key_rec_t  mem_rd_r;
  logic                vld_rd_r;
  logic                valid_r [akrt_pkg::NUM_KEYS];

  akrt_pkg::work_t     item_r;
  akrt_pkg::key_rec_t  rec_r;
  akrt_pkg::out_item_t res_r;
  logic                skip_r;
  logic [11:0]         value_r;
  logic [11:0]         dist_r;
  logic [1:0]          ev_r;
  logic                lay_r;
  logic                scan_trig_r;

  logic                mem_we;
  logic                div_start;
  logic                div_done;
  logic [7:0]          div_quot;

  // calibration and drift
  logic [15:0]         s16;
  logic [23:0]         cal_mix;
  logic [23:0]         drift_mix;
  logic                cal_warm;
  logic                rises;

  // distance
  logic signed [13:0]  thresh;
  logic signed [13:0]  val_s;
  logic                at_rest;
  logic                go_sleep;
  logic [11:0]         dist_raw;
  logic signed [13:0]  bottom_lim;
  logic [11:0]         dist_clamped;
  logic [19:0]         div_num;

  // filter
  logic [15:0]         filt_new;
  logic [7:0]          old8;
  logic signed [8:0]   vel;

  // actuation
  logic signed [10:0]  d_s;
  logic signed [10:0]  rbase;
  logic [7:0]          reset_lvl;
  logic                after_trig;
  logic                before_reset;
  logic                rapid_on;
  logic                after_rapid;
  logic                before_rapid;
  logic                has_tap;
  logic                in_time;
  akrt_pkg::phase_t    ph_new;
  logic [1:0]          ev_new;
  logic                lay_new;
  logic                set_scan;
  logic                set_time;

  akrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (rec_r.max_travel),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---- datapath arithmetic
  assign s16       = {item_r.sample, 4'd0};
  assign cal_mix   = 24'd102 * 24'(s16) + 24'd154 * 24'(rec_r.idle_level);
  assign drift_mix = 24'd51 * 24'(s16) + 24'd205 * 24'(rec_r.idle_level);
  assign cal_warm  = (rec_r.cal_count < 5'(akrt_pkg::CAL_SAMPLES));
  assign rises     = (s16 > rec_r.idle_level);

  assign thresh   = $signed({2'd0, rec_r.idle_level[15:4]}) - $signed({2'd0, cfg.idle_margin});
  assign val_s    = $signed({2'd0, value_r});
  assign at_rest  = (val_s >= thresh);
  assign go_sleep = (rec_r.prev_travel == 12'd0) && at_rest &&
                    (rec_r.quiet_count >= cfg.sleep_count);
  assign dist_raw = at_rest ? 12'd0 : 12'(thresh - val_s);

  assign bottom_lim   = $signed({2'd0, rec_r.max_travel}) - $signed({2'd0, cfg.bottom_margin});
  assign dist_clamped = ($signed({2'd0, dist_r}) >= bottom_lim) ? rec_r.max_travel : dist_r;
  assign div_num      = {dist_clamped, 8'd0} - {8'd0, dist_clamped};

  assign filt_new = 16'((24'd51 * {8'd0, rec_r.travel_scaled, 8'd0} +
                         24'd205 * 24'(rec_r.filtered_travel)) >> 8);
  assign old8     = rec_r.filtered_travel[15:8];
  assign vel      = $signed({1'b0, filt_new[15:8]}) - $signed({1'b0, old8});

  assign d_s          = $signed({3'd0, rec_r.travel_scaled});
  assign reset_lvl    = (cfg.trigger_level > cfg.reset_gap) ?
                        (cfg.trigger_level - cfg.reset_gap) : 8'd0;
  assign after_trig   = (rec_r.travel_scaled > cfg.trigger_level);
  assign before_reset = (rec_r.travel_scaled < reset_lvl);
  assign rapid_on     = (cfg.rapid_gap != 8'd0);
  assign rbase        = $signed({3'd0, rec_r.turn_point}) - $signed({3'd0, cfg.rapid_gap});
  assign after_rapid  = d_s > (rbase + $signed({3'd0, cfg.reset_gap}));
  assign before_rapid = d_s < rbase;
  assign has_tap      = cfg.tap_key_mask[item_r.key];
  assign in_time      = ((item_r.now_ms - rec_r.trigger_time) <= {16'd0, cfg.tap_window_ms});

  // actuation machine and tap resolve
  always_comb begin
    ph_new   = rec_r.phase;
    ev_new   = akrt_pkg::EV_NONE;
    lay_new  = 1'b0;
    set_scan = 1'b0;
    set_time = 1'b0;
    if (item_r.op == akrt_pkg::OP_TAP) begin
      if (rec_r.phase == akrt_pkg::PH_MAYBE_TAP) begin
        priority if (before_reset && in_time) begin
          ph_new  = akrt_pkg::PH_TAP;
          ev_new  = akrt_pkg::EV_PRESS;
          lay_new = 1'b1;
        end else if (!in_time || scan_trig_r) begin
          ph_new = akrt_pkg::PH_TRIG;
          ev_new = akrt_pkg::EV_PRESS;
        end else begin
          ph_new = rec_r.phase;
        end
      end
    end else begin
      unique case (rec_r.phase)
        akrt_pkg::PH_RESET: begin
          if (after_trig) begin
            set_time = 1'b1;
            if (has_tap) begin
              ph_new = akrt_pkg::PH_MAYBE_TAP;
            end else begin
              ph_new   = akrt_pkg::PH_TRIG;
              set_scan = 1'b1;
              ev_new   = akrt_pkg::EV_PRESS;
            end
          end
        end
        akrt_pkg::PH_RAPID: begin
          priority if (!rapid_on) begin
            ph_new = akrt_pkg::PH_RESET;
          end else if (after_trig && rec_r.heading == akrt_pkg::DIR_DOWN && after_rapid) begin
            set_scan = 1'b1;
            set_time = 1'b1;
            if (has_tap) begin
              ph_new = akrt_pkg::PH_MAYBE_TAP;
            end else begin
              ph_new = akrt_pkg::PH_TRIG;
              ev_new = akrt_pkg::EV_PRESS;
            end
          end else if (before_reset) begin
            ph_new = akrt_pkg::PH_RESET;
          end else begin
            ph_new = rec_r.phase;
          end
        end
        akrt_pkg::PH_TAP: begin
          ph_new  = akrt_pkg::PH_RESET;
          ev_new  = akrt_pkg::EV_RELEASE;
          lay_new = 1'b1;
        end
        akrt_pkg::PH_TRIG: begin
          priority if (before_reset) begin
            ph_new = akrt_pkg::PH_RESET;
            ev_new = akrt_pkg::EV_RELEASE;
          end else if (rapid_on && rec_r.heading == akrt_pkg::DIR_UP && before_rapid) begin
            ph_new = akrt_pkg::PH_RAPID;
            ev_new = akrt_pkg::EV_RELEASE;
          end else begin
            ph_new = rec_r.phase;
          end
        end
        default: ph_new = rec_r.phase;
      endcase
    end
  end

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      akrt_pkg::ST_IDLE:  if (fr_valid) state_nxt = akrt_pkg::ST_LOAD;
      akrt_pkg::ST_LOAD: begin
        unique case (item_r.op)
          akrt_pkg::OP_SAMPLE: state_nxt = akrt_pkg::ST_CAL;
          akrt_pkg::OP_TAP:    state_nxt = akrt_pkg::ST_ACT;
          default:             state_nxt = akrt_pkg::ST_WB;
        endcase
      end
      akrt_pkg::ST_CAL:   state_nxt = cal_warm ? akrt_pkg::ST_WB : akrt_pkg::ST_DIST;
      akrt_pkg::ST_DIST:  state_nxt = go_sleep ? akrt_pkg::ST_WB : akrt_pkg::ST_CLAMP;
      akrt_pkg::ST_CLAMP: state_nxt = akrt_pkg::ST_DIV;
      akrt_pkg::ST_DIV:   if (div_done) state_nxt = akrt_pkg::ST_FILT;
      akrt_pkg::ST_FILT:  state_nxt = akrt_pkg::ST_ACT;
      akrt_pkg::ST_ACT:   state_nxt = akrt_pkg::ST_WB;
      akrt_pkg::ST_WB:    state_nxt = akrt_pkg::ST_OUT;
      akrt_pkg::ST_OUT:   if (res_ready) state_nxt = akrt_pkg::ST_IDLE;
      default:            state_nxt = akrt_pkg::ST_IDLE;
    endcase
  end

  // ---- control outputs
  always_comb begin
    fr_pop    = (state_r == akrt_pkg::ST_IDLE) && fr_valid;
    div_start = (state_r == akrt_pkg::ST_CLAMP);
    mem_we    = (state_r == akrt_pkg::ST_WB);
    res_valid = (state_r == akrt_pkg::ST_OUT);
  end

  assign res_item = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= akrt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // key record store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item_r.key] <= rec_r;
    end
    mem_rd_r <= mem[fr_work.key];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < akrt_pkg::NUM_KEYS; i++) valid_r[i] <= 1'b0;
      vld_rd_r    <= 1'b0;
      scan_trig_r <= 1'b0;
    end else begin
      vld_rd_r <= valid_r[fr_work.key];
      if (mem_we) valid_r[item_r.key] <= 1'b1;
      if (state_r == akrt_pkg::ST_ACT && set_scan) scan_trig_r <= 1'b1;
      if (state_r == akrt_pkg::ST_WB && item_r.op == akrt_pkg::OP_SCAN) scan_trig_r <= 1'b0;
    end
  end

  // working record
  always_ff @(posedge clk) begin
    unique case (state_r)
      akrt_pkg::ST_IDLE: begin
        item_r <= fr_work;
        skip_r <= 1'b0;
        ev_r   <= akrt_pkg::EV_NONE;
        lay_r  <= 1'b0;
      end
      akrt_pkg::ST_LOAD: begin
        rec_r <= vld_rd_r ? mem_rd_r : akrt_pkg::REC_RESET;
      end
      akrt_pkg::ST_CAL: begin
        if (cal_warm) begin
          rec_r.idle_level <= cal_mix[23:8];
          rec_r.cal_count  <= rec_r.cal_count + 5'd1;
          skip_r           <= 1'b1;
        end else if (rises) begin
          rec_r.idle_level <= drift_mix[23:8];
          value_r          <= drift_mix[23:12];
        end else begin
          value_r <= item_r.sample;
        end
      end
      akrt_pkg::ST_DIST: begin
        if (go_sleep) begin
          rec_r.asleep <= 1'b1;
          skip_r       <= 1'b1;
        end else begin
          if (at_rest) begin
            rec_r.turn_point <= 8'd0;
            if (rec_r.prev_travel == 12'd0 && rec_r.quiet_count != 16'hFFFF) begin
              rec_r.quiet_count <= rec_r.quiet_count + 16'd1;
            end
          end else begin
            rec_r.asleep      <= 1'b0;
            rec_r.quiet_count <= 16'd0;
          end
          if (dist_raw > rec_r.max_travel) rec_r.max_travel <= dist_raw;
          dist_r <= dist_raw;
        end
      end
      akrt_pkg::ST_CLAMP: begin
        dist_r            <= dist_clamped;
        rec_r.prev_travel <= dist_clamped;
      end
      akrt_pkg::ST_DIV: begin
        if (div_done) begin
          rec_r.travel_scaled <= (rec_r.max_travel == 12'd0) ? 8'd0 : div_quot;
        end
      end
      akrt_pkg::ST_FILT: begin
        // turn point takes old filtered level on a turn, except 0 down, FF up
        priority if (rec_r.speed > 0 && vel > 0 && rec_r.heading != akrt_pkg::DIR_DOWN) begin
          rec_r.heading <= akrt_pkg::DIR_DOWN;
          if (rec_r.turn_point != 8'd0) rec_r.turn_point <= old8;
        end else if (rec_r.speed < 0 && vel < 0 && rec_r.heading != akrt_pkg::DIR_UP) begin
          rec_r.heading <= akrt_pkg::DIR_UP;
          if (rec_r.turn_point != 8'hFF) rec_r.turn_point <= old8;
        end else begin
          rec_r.heading <= rec_r.heading;
        end
        rec_r.filtered_travel <= filt_new;
        rec_r.speed           <= vel;
      end
      akrt_pkg::ST_ACT: begin
        rec_r.phase <= ph_new;
        if (set_time) rec_r.trigger_time <= item_r.now_ms;
        ev_r  <= ev_new;
        lay_r <= lay_new;
      end
      akrt_pkg::ST_WB: begin
        res_r.key_out      <= item_r.key;
        res_r.event_res    <= ev_r;
        res_r.layer        <= (ev_r != akrt_pkg::EV_NONE) ? lay_r : 1'b0;
        res_r.travel_level <= ({1'b0, item_r.key} < 7'(akrt_pkg::NUM_KEYS)) ?
                              rec_r.travel_scaled : 8'd0;
        res_r.sleeping     <= ({1'b0, item_r.key} < 7'(akrt_pkg::NUM_KEYS)) ?
                              rec_r.asleep : 1'b0;
      end
      akrt_pkg::ST_OUT: begin
        dist_r <= dist_r;
      end
      default: begin
        skip_r <= skip_r;
      end
    endcase
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == akrt_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == akrt_pkg::ST_OUT && res_ready |=> state_r == akrt_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after handing off a result");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fr_pop |=> state_r == akrt_pkg::ST_LOAD)
    else $error("item taken from the queue without a record load");

  a_layer_event: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_r.layer |-> res_r.event_res != akrt_pkg::EV_NONE)
    else $error("tap layer flagged on a result without an event");

  a_skip_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == akrt_pkg::ST_WB && skip_r && item_r.op == akrt_pkg::OP_SAMPLE
      |-> ev_r == akrt_pkg::EV_NONE)
    else $error("event raised on a warm-up or sleeping sample");

endmodule

/* rtl/core/analog_key_rapid_trigger.sv */
// ----------------------------------------------------------------------------
// analog_key_rapid_trigger
// Rapid-trigger actuation for up to 64 Hall-effect keys with per-key
// calibration, travel scaling, filtering and tap/hold resolution.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise push; the item is taken on a clock
//   edge where push is high and full is low. A two-entry queue buffers items.
//   Result channel: while empty is low the oldest result sits on out_item;
//   raise pop to take it. Exactly one result comes out per item, in order.
//   Configuration: APB-style port, one 64-bit register every 8 bytes; write
//   registers only while the block is idle.
// Sequencing:
//   One item is worked on at a time. A key sample passes queue pop, record
//   read, calibration, distance, clamp, the eight-step divide, filter,
//   actuation, write-back and hand off. A warm-up sample goes from
//   calibration, a sample that puts its key to sleep from distance, and a
//   scan start or an ignored request from record read straight to
//   write-back; a tap resolve goes from record read to actuation.
// Reset: synchronous active-low; empty both queues, load the register
//   defaults and mark every key record fresh, so it reads as its start values.
// Stalls: with pop held low the result queue fills, the sequencer holds its
//   last result and the input queue then raises full.
// ----------------------------------------------------------------------------
module analog_key_rapid_trigger (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               push,
  output logic                               full,
  input  akrt_pkg::in_item_t                 in_item,
  // result channel
  output logic                               empty,
  input  logic                               pop,
  output akrt_pkg::out_item_t                out_item,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [akrt_pkg::ADDR_W-1:0]        paddr,
  input  logic [akrt_pkg::DATA_W-1:0]        pwdata,
  output logic [akrt_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  akrt_pkg::cfg_t      cfg_r;
  akrt_pkg::work_t     fr_work;
  logic                fr_valid;
  logic                fr_pop;
  logic                res_valid;
  logic                res_ready;
  akrt_pkg::out_item_t res_item;
  logic                cfg_we;
  logic [2:0]          reg_sel;

  akrt_pkg::out_item_t oq_r [2];
  logic                oq_wr_r;
  logic                oq_rd_r;
  logic [1:0]          oq_cnt_r;
  logic                oq_push;
  logic                oq_pop;

  // front: accept and decode items
  akrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .fr_valid (fr_valid),
    .fr_pop   (fr_pop),
    .fr_work  (fr_work)
  );

  // back: per-key processing
  akrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fr_valid  (fr_valid),
    .fr_pop    (fr_pop),
    .fr_work   (fr_work),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // ---- configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_level <= 8'd128;
      cfg_r.reset_gap     <= 8'd16;
      cfg_r.rapid_gap     <= 8'd0;
      cfg_r.tap_window_ms <= 16'd200;
      cfg_r.tap_key_mask  <= 64'd0;
      cfg_r.idle_margin   <= 12'd50;
      cfg_r.bottom_margin <= 12'd50;
      cfg_r.sleep_count   <= 16'd1000;
    end else if (cfg_we) begin
      unique case (reg_sel)
        akrt_pkg::REG_TRIGGER_LEVEL: cfg_r.trigger_level <= pwdata[7:0];
        akrt_pkg::REG_RESET_GAP:     cfg_r.reset_gap     <= pwdata[7:0];
        akrt_pkg::REG_RAPID_GAP:     cfg_r.rapid_gap     <= pwdata[7:0];
        akrt_pkg::REG_TAP_WINDOW:    cfg_r.tap_window_ms <= pwdata[15:0];
        akrt_pkg::REG_TAP_MASK:      cfg_r.tap_key_mask  <= pwdata;
        akrt_pkg::REG_IDLE_MARGIN:   cfg_r.idle_margin   <= pwdata[11:0];
        akrt_pkg::REG_BOTTOM_MARGIN: cfg_r.bottom_margin <= pwdata[11:0];
        akrt_pkg::REG_SLEEP_COUNT:   cfg_r.sleep_count   <= pwdata[15:0];
        default:                     cfg_r.sleep_count   <= cfg_r.sleep_count;
      endcase
    end
  end

  // read back the selected register, zero-extended
  always_comb begin
    unique case (reg_sel)
      akrt_pkg::REG_TRIGGER_LEVEL: prdata = {56'd0, cfg_r.trigger_level};
      akrt_pkg::REG_RESET_GAP:     prdata = {56'd0, cfg_r.reset_gap};
      akrt_pkg::REG_RAPID_GAP:     prdata = {56'd0, cfg_r.rapid_gap};
      akrt_pkg::REG_TAP_WINDOW:    prdata = {48'd0, cfg_r.tap_window_ms};
      akrt_pkg::REG_TAP_MASK:      prdata = cfg_r.tap_key_mask;
      akrt_pkg::REG_IDLE_MARGIN:   prdata = {52'd0, cfg_r.idle_margin};
      akrt_pkg::REG_BOTTOM_MARGIN: prdata = {52'd0, cfg_r.bottom_margin};
      akrt_pkg::REG_SLEEP_COUNT:   prdata = {48'd0, cfg_r.sleep_count};
      default:                     prdata = '0;
    endcase
  end

  // ---- result queue: hold finished items until the receiver pops them
  assign res_ready = (oq_cnt_r != 2'd2);
  assign oq_push   = res_valid && res_ready;
  assign oq_pop    = pop && !empty;
  assign empty     = (oq_cnt_r == 2'd0);
  assign out_item  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) oq_wr_r <= !oq_wr_r;
      if (oq_pop)  oq_rd_r <= !oq_rd_r;
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

endmodule
